/* design/ese_pkg.sv */
// ----------------------------------------------------------------------------
// ese_pkg: element strain energy package
// Payload types, fixed-point widths and the stiffness index tables of the
// four-node plane-stress element.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int NUM_DOF   = 8;
  localparam int NUM_COEFF = 8;
  // Off-diagonal coefficients k1..k7; each one is shared by four dof pairs.
  localparam int NUM_OFF   = NUM_COEFF - 1;
  localparam int PAIR_N    = 4;

  localparam int CFG_IDX_W = $clog2(NUM_COEFF);
  localparam int COEFF_W   = 24;
  localparam int U_W       = 32;
  localparam int OUT_W     = 64;
  localparam int FRAC_SHIFT = 20;

  // Product u_i*u_j, sum of four products, coefficient-grouped sum.
  localparam int PROD_W = 2 * U_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int GSUM_W = PSUM_W + 1;
  // Grouped sum is multiplied in a high signed part and a low unsigned part.
  localparam int LO_W   = 32;
  localparam int HI_W   = GSUM_W - LO_W;
  localparam int PH_W   = HI_W + COEFF_W;
  localparam int PL_W   = LO_W + 1 + COEFF_W;
  // Exact sum of all terms needs 93 bits; one spare bit of headroom.
  localparam int ACC_W  = 94;
  localparam int SH_W   = ACC_W - FRAC_SHIFT;

  typedef logic [2:0] dof_idx_t;

  // Dof pairs (a < b) that share coefficient k(c+1) in the stiffness pattern.
  localparam dof_idx_t PAIR_A [NUM_OFF][PAIR_N] = '{
    '{3'd0, 3'd2, 3'd3, 3'd4},
    '{3'd0, 3'd1, 3'd3, 3'd4},
    '{3'd0, 3'd1, 3'd2, 3'd4},
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd6},
    '{3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd1, 3'd3, 3'd5}
  };
  localparam dof_idx_t PAIR_B [NUM_OFF][PAIR_N] = '{
    '{3'd1, 3'd7, 3'd6, 3'd5},
    '{3'd2, 3'd7, 3'd5, 3'd6},
    '{3'd3, 3'd6, 3'd5, 3'd7},
    '{3'd4, 3'd5, 3'd6, 3'd7},
    '{3'd5, 3'd4, 3'd3, 3'd7},
    '{3'd6, 3'd3, 3'd4, 3'd7},
    '{3'd7, 3'd2, 3'd4, 3'd6}
  };

  typedef struct packed {
    logic signed [U_W-1:0] u0;
    logic signed [U_W-1:0] u1;
    logic signed [U_W-1:0] u2;
    logic signed [U_W-1:0] u3;
    logic signed [U_W-1:0] u4;
    logic signed [U_W-1:0] u5;
    logic signed [U_W-1:0] u6;
    logic signed [U_W-1:0] u7;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] strain_energy;
    logic                    saturated;
  } out_item_t;

endpackage

/* design/element_strain_energy_top.sv */
// ----------------------------------------------------------------------------
// element_strain_energy_top: Q4 element strain energy ue^T * KE * ue
// Eight-stage pipeline: products, grouped sums, coefficient multiply,
// reduction tree, scaling and saturation.
// ----------------------------------------------------------------------------
// The block accepts one element (eight Q16.16 displacements) per clock
// unless in_stall is high, and returns its strain energy in Q32.32. The
// pipeline has one stage of 32x32 products, two stages that group the
// products by stiffness coefficient, one stage of coefficient multiplies and
// three stages of adders that reduce the 94-bit exact sum, then the shift and
// saturation stage that loads the output register. When out_stall holds a
// result, the whole pipeline holds and in_stall rises in the same cycle.
// Coefficients k0..k7 (Q4.20) are written through the cfg port, which is
// always ready; write them only while no item is in flight.
module element_strain_energy_top
  import ese_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data
);

  localparam int NSTG = 8;

  logic                      adv;
  logic [NSTG-1:0]           vld_r, vld_nxt;
  logic signed [COEFF_W-1:0] coeff_r [NUM_COEFF];
  logic signed [U_W-1:0]     u_a [NUM_DOF];

  logic signed [PROD_W-1:0]  dsq_r [NUM_DOF];
  logic signed [PROD_W-1:0]  dsq_nxt [NUM_DOF];
  logic signed [PROD_W-1:0]  off_r [NUM_OFF][PAIR_N];
  logic signed [PROD_W-1:0]  off_nxt [NUM_OFF][PAIR_N];
  logic signed [PSUM_W-1:0]  dsum_r [2];
  logic signed [PSUM_W-1:0]  dsum_nxt [2];
  logic signed [PSUM_W-1:0]  osum_r [NUM_OFF];
  logic signed [PSUM_W-1:0]  osum_nxt [NUM_OFF];
  logic signed [GSUM_W-1:0]  gs_r [NUM_COEFF];
  logic signed [GSUM_W-1:0]  gs_nxt [NUM_COEFF];
  logic signed [PH_W-1:0]    ph_r [NUM_COEFF];
  logic signed [PH_W-1:0]    ph_nxt [NUM_COEFF];
  logic signed [PL_W-1:0]    pl_r [NUM_COEFF];
  logic signed [PL_W-1:0]    pl_nxt [NUM_COEFF];
  logic signed [ACC_W-1:0]   term_r [NUM_COEFF];
  logic signed [ACC_W-1:0]   term_nxt [NUM_COEFF];
  logic signed [ACC_W-1:0]   pair_r [NUM_COEFF/2];
  logic signed [ACC_W-1:0]   pair_nxt [NUM_COEFF/2];
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  out_item_t                 out_r, out_nxt;

  // The pipeline moves as a whole unless a finished result is held.
  assign adv       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign u_a[0] = in_data.u0;
  assign u_a[1] = in_data.u1;
  assign u_a[2] = in_data.u2;
  assign u_a[3] = in_data.u3;
  assign u_a[4] = in_data.u4;
  assign u_a[5] = in_data.u5;
  assign u_a[6] = in_data.u6;
  assign u_a[7] = in_data.u7;

  assign vld_nxt = {vld_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COEFF; c++) begin
        coeff_r[c] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      coeff_r[cfg_index] <= $signed(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1: squares on the diagonal and off-diagonal products by group.
  always_comb begin
    for (int i = 0; i < NUM_DOF; i++) begin
      dsq_nxt[i] = PROD_W'(u_a[i]) * PROD_W'(u_a[i]);
    end
    for (int c = 0; c < NUM_OFF; c++) begin
      for (int n = 0; n < PAIR_N; n++) begin
        off_nxt[c][n] = PROD_W'(u_a[PAIR_A[c][n]]) * PROD_W'(u_a[PAIR_B[c][n]]);
      end
    end
  end

  // Stage 2: sums of four products.
  always_comb begin
    dsum_nxt[0] = PSUM_W'(dsq_r[0]) + PSUM_W'(dsq_r[1])
                + PSUM_W'(dsq_r[2]) + PSUM_W'(dsq_r[3]);
    dsum_nxt[1] = PSUM_W'(dsq_r[4]) + PSUM_W'(dsq_r[5])
                + PSUM_W'(dsq_r[6]) + PSUM_W'(dsq_r[7]);
    for (int c = 0; c < NUM_OFF; c++) begin
      osum_nxt[c] = PSUM_W'(off_r[c][0]) + PSUM_W'(off_r[c][1])
                  + PSUM_W'(off_r[c][2]) + PSUM_W'(off_r[c][3]);
    end
  end

  // Stage 3: one grouped sum per coefficient; off-diagonal pairs count twice.
  always_comb begin
    gs_nxt[0] = GSUM_W'(dsum_r[0]) + GSUM_W'(dsum_r[1]);
    for (int c = 0; c < NUM_OFF; c++) begin
      gs_nxt[c+1] = GSUM_W'(osum_r[c]) <<< 1;
    end
  end

  // Stage 4: coefficient times grouped sum, split into a signed high part
  // and an unsigned low part.
  always_comb begin
    for (int c = 0; c < NUM_COEFF; c++) begin
      ph_nxt[c] = PH_W'($signed(gs_r[c][GSUM_W-1:LO_W])) * PH_W'(coeff_r[c]);
      pl_nxt[c] = PL_W'($signed({1'b0, gs_r[c][LO_W-1:0]})) * PL_W'(coeff_r[c]);
    end
  end

  // Stages 5 to 7: recombine the halves and reduce the eight terms.
  always_comb begin
    for (int c = 0; c < NUM_COEFF; c++) begin
      term_nxt[c] = (ACC_W'(ph_r[c]) <<< LO_W) + ACC_W'(pl_r[c]);
    end
    for (int k = 0; k < NUM_COEFF/2; k++) begin
      pair_nxt[k] = term_r[2*k] + term_r[2*k+1];
    end
    acc_nxt = pair_r[0] + pair_r[1] + pair_r[2] + pair_r[3];
  end

  // Stage 8: drop the low fraction bits and saturate to 64 bits.
  always_comb begin
    logic [SH_W-1:0] sh;
    logic            fits;
    sh   = acc_r[ACC_W-1:FRAC_SHIFT];
    fits = (&sh[SH_W-1:OUT_W-1]) || !(|sh[SH_W-1:OUT_W-1]);
    out_nxt.saturated = !fits;
    if (fits) begin
      out_nxt.strain_energy = $signed(sh[OUT_W-1:0]);
    end else if (acc_r[ACC_W-1]) begin
      out_nxt.strain_energy = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      out_nxt.strain_energy = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq_r  <= dsq_nxt;
      off_r  <= off_nxt;
      dsum_r <= dsum_nxt;
      osum_r <= osum_nxt;
      gs_r   <= gs_nxt;
      ph_r   <= ph_nxt;
      pl_r   <= pl_nxt;
      term_r <= term_nxt;
      pair_r <= pair_nxt;
      acc_r  <= acc_nxt;
      out_r  <= out_nxt;
    end
  end

endmodule

/* design/ese_checker.sv */
// ----------------------------------------------------------------------------
// ese_checker: port-level checks for element_strain_energy_top
// Watches the handshakes and the saturated result encoding.
// ----------------------------------------------------------------------------
module ese_checker
  import ese_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A held result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // The input side only stalls when a result is held at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a held result");

  // A saturated item carries one of the two 64-bit limits.
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.strain_energy == {1'b1, {(OUT_W-1){1'b0}}} ||
      out_data.strain_energy == {1'b0, {(OUT_W-1){1'b1}}})
    else $error("saturated item without a limit value");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind element_strain_energy_top ese_checker u_ese_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
